FILE: hw/rtl/eegp2_pkg.sv
// ----------------------------------------------------------------------------
// EEG P2 packet parser package
// Shared constants and types for the P2 packet parser and its channels.
// ----------------------------------------------------------------------------
package eegp2_pkg;

   // Number of EEG channels carried in a P2 packet.
   localparam int CHANNELS = 6;

   // Field widths.
   localparam int BYTE_W   = 8;
   localparam int WORD_W   = 16;
   localparam int CHAN_W   = 17;
   localparam int COUNT_W  = 3;
   localparam int POS_W    = 4;

   // Framing constants.
   localparam logic [BYTE_W-1:0]  SYNC_FIRST  = 8'd165;
   localparam logic [BYTE_W-1:0]  SYNC_SECOND = 8'd90;
   localparam logic [POS_W-1:0]   DATA_BYTES  = 4'd12;
   localparam logic [CHAN_W-1:0]  CHAN_OFFSET = 17'd512;
   localparam logic [COUNT_W-1:0] COUNT_RESET = 3'(CHANNELS);

   // Parser phase.
   typedef enum logic [2:0] {
      PH_HUNT    = 3'd0,
      PH_SYNC2   = 3'd1,
      PH_VERSION = 3'd2,
      PH_NUMBER  = 3'd3,
      PH_DATA    = 3'd4
   } phase_type;

   typedef logic signed [CHAN_W-1:0] chan_type;

endpackage

FILE: hw/rtl/eegp2_if.sv
// ----------------------------------------------------------------------------
// EEG P2 packet parser channels
// Valid/ready channels for received bytes, parsed packets and the
// channel-count register write.
// ----------------------------------------------------------------------------

// Received byte channel.
interface eegp2_req_if;
   logic                        valid;
   logic                        ready;
   logic [eegp2_pkg::BYTE_W-1:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

// Parsed packet channel.
interface eegp2_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [eegp2_pkg::BYTE_W-1:0] packet_number;
   logic [eegp2_pkg::BYTE_W-1:0] switches;
   eegp2_pkg::chan_type         chan0;
   eegp2_pkg::chan_type         chan1;
   eegp2_pkg::chan_type         chan2;
   eegp2_pkg::chan_type         chan3;
   eegp2_pkg::chan_type         chan4;
   eegp2_pkg::chan_type         chan5;

   modport source (output valid, output packet_number, output switches,
                   output chan0, output chan1, output chan2, output chan3,
                   output chan4, output chan5, input ready);
   modport sink   (input valid, input packet_number, input switches,
                   input chan0, input chan1, input chan2, input chan3,
                   input chan4, input chan5, output ready);
endinterface

// Channel-count register write channel.
interface eegp2_csr_if;
   logic                          valid;
   logic                          ready;
   logic [eegp2_pkg::COUNT_W-1:0] channel_count;

   modport source (output valid, output channel_count, input ready);
   modport sink   (input valid, input channel_count, output ready);
endinterface

FILE: hw/rtl/eeg_p2_packet_parser_core.sv
// ----------------------------------------------------------------------------
// EEG P2 packet parser core
// Hunts for the 165/90 sync pair in a byte stream, collects the packet
// number and six big-endian channel words, and emits one packet word on
// the switches byte with each channel offset by -512.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Payload                                  Role
//   req_ch    in         rx_byte                                  serial bytes
//   rsp_ch    out        packet_number, switches, chan0..chan5    parsed packet
//   csr_ch    in         channel_count                            register write
//
// A byte is captured in an input register and parsed from there; one byte
// per cycle is sustained unless a finished packet word waits on a stalled
// output, and a packet word is registered in the output register when its
// switches byte is parsed. The phase update between the two is combinational.
// Reset is synchronous and active high; it returns the parser to hunting,
// clears the stored channel words and sets the channel count to six.
// A stalled output only holds bytes back when the byte under parse would
// produce a new packet word; all other bytes keep flowing.
module eeg_p2_packet_parser_core (
   input  logic              clock,
   input  logic              reset,
   eegp2_req_if.sink         req_ch,
   eegp2_rsp_if.source       rsp_ch,
   eegp2_csr_if.sink         csr_ch
);

   // Input register.
   logic                           in_valid_ff, in_valid_in;
   logic [eegp2_pkg::BYTE_W-1:0]   in_byte_ff;

   // Parser state.
   eegp2_pkg::phase_type           phase_ff, phase_in;
   logic [eegp2_pkg::POS_W-1:0]    pos_ff, pos_in;
   logic [eegp2_pkg::BYTE_W-1:0]   number_ff, number_in;
   logic [eegp2_pkg::WORD_W-1:0]   words_ff [eegp2_pkg::CHANNELS];
   logic [eegp2_pkg::WORD_W-1:0]   words_in [eegp2_pkg::CHANNELS];
   logic [eegp2_pkg::COUNT_W-1:0]  count_ff;

   // Output register.
   logic                           out_valid_ff, out_valid_in;
   logic [eegp2_pkg::BYTE_W-1:0]   out_number_ff;
   logic [eegp2_pkg::BYTE_W-1:0]   out_switches_ff;
   eegp2_pkg::chan_type            out_chan_ff [eegp2_pkg::CHANNELS];
   eegp2_pkg::chan_type            out_chan_in [eegp2_pkg::CHANNELS];

   // Parse controls.
   logic                           is_result;
   logic                           out_free;
   logic                           proc_fire;
   logic [eegp2_pkg::COUNT_W-1:0]  eff_count;
   logic [eegp2_pkg::COUNT_W-1:0]  data_chan;

   // Effective channel count is the register limited to the channel total.
   assign eff_count = (count_ff > eegp2_pkg::COUNT_RESET) ?
                      eegp2_pkg::COUNT_RESET : count_ff;
   assign data_chan = eegp2_pkg::COUNT_W'(pos_ff >> 1);

   // A byte is parsed when present, unless it ends a packet and the output
   // register is still occupied.
   assign is_result = (phase_ff == eegp2_pkg::PH_DATA) &&
                      (pos_ff >= eegp2_pkg::DATA_BYTES);
   assign out_free  = !out_valid_ff || rsp_ch.ready;
   assign proc_fire = in_valid_ff && (!is_result || out_free);

   assign req_ch.ready = !in_valid_ff || proc_fire;
   assign csr_ch.ready = 1'b1;

   assign in_valid_in  = req_ch.valid || (in_valid_ff && !proc_fire);
   assign out_valid_in = (proc_fire && is_result) || (out_valid_ff && !rsp_ch.ready);

   // Next phase.
   always_comb begin
      phase_in = phase_ff;
      if (proc_fire) begin
         unique case (phase_ff)
            eegp2_pkg::PH_HUNT: begin
               if (in_byte_ff == eegp2_pkg::SYNC_FIRST) phase_in = eegp2_pkg::PH_SYNC2;
            end
            eegp2_pkg::PH_SYNC2: begin
               phase_in = (in_byte_ff == eegp2_pkg::SYNC_SECOND) ?
                          eegp2_pkg::PH_VERSION : eegp2_pkg::PH_HUNT;
            end
            eegp2_pkg::PH_VERSION: phase_in = eegp2_pkg::PH_NUMBER;
            eegp2_pkg::PH_NUMBER:  phase_in = eegp2_pkg::PH_DATA;
            eegp2_pkg::PH_DATA: begin
               if (is_result) phase_in = eegp2_pkg::PH_HUNT;
            end
            default: phase_in = eegp2_pkg::PH_HUNT;
         endcase
      end
   end

   // Packet number and byte position.
   always_comb begin
      number_in = number_ff;
      pos_in    = pos_ff;
      if (proc_fire && phase_ff == eegp2_pkg::PH_NUMBER) begin
         number_in = in_byte_ff;
         pos_in    = '0;
      end else if (proc_fire && phase_ff == eegp2_pkg::PH_DATA && !is_result) begin
         pos_in = pos_ff + 1'b1;
      end
   end

   // Channel word lanes: high byte loads, low byte adds into the word.
   always_comb begin
      for (int j = 0; j < eegp2_pkg::CHANNELS; j++) begin
         words_in[j] = words_ff[j];
         if (proc_fire && phase_ff == eegp2_pkg::PH_DATA && !is_result &&
             data_chan == eegp2_pkg::COUNT_W'(j) &&
             eegp2_pkg::COUNT_W'(j) < eff_count) begin
            if (!pos_ff[0]) words_in[j] = {in_byte_ff, 8'h00};
            else            words_in[j] = words_ff[j] + {8'h00, in_byte_ff};
         end
      end
   end

   // Reported channel values; unused channels read as zero.
   always_comb begin
      for (int j = 0; j < eegp2_pkg::CHANNELS; j++) begin
         if (eegp2_pkg::COUNT_W'(j) < eff_count)
            out_chan_in[j] = eegp2_pkg::chan_type'({1'b0, words_ff[j]} -
                                                   eegp2_pkg::CHAN_OFFSET);
         else
            out_chan_in[j] = '0;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         phase_ff     <= eegp2_pkg::PH_HUNT;
         pos_ff       <= '0;
         number_ff    <= '0;
         count_ff     <= eegp2_pkg::COUNT_RESET;
         for (int j = 0; j < eegp2_pkg::CHANNELS; j++) words_ff[j] <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         phase_ff     <= phase_in;
         pos_ff       <= pos_in;
         number_ff    <= number_in;
         for (int j = 0; j < eegp2_pkg::CHANNELS; j++) words_ff[j] <= words_in[j];
         if (csr_ch.valid) count_ff <= csr_ch.channel_count;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_ch.valid && req_ch.ready) in_byte_ff <= req_ch.rx_byte;
      if (proc_fire && is_result) begin
         out_number_ff   <= number_ff;
         out_switches_ff <= in_byte_ff;
         for (int j = 0; j < eegp2_pkg::CHANNELS; j++) out_chan_ff[j] <= out_chan_in[j];
      end
   end

   // Output channel.
   assign rsp_ch.valid         = out_valid_ff;
   assign rsp_ch.packet_number = out_number_ff;
   assign rsp_ch.switches      = out_switches_ff;
   assign rsp_ch.chan0         = out_chan_ff[0];
   assign rsp_ch.chan1         = out_chan_ff[1];
   assign rsp_ch.chan2         = out_chan_ff[2];
   assign rsp_ch.chan3         = out_chan_ff[3];
   assign rsp_ch.chan4         = out_chan_ff[4];
   assign rsp_ch.chan5         = out_chan_ff[5];

endmodule

FILE: hw/rtl/eegp2_checker.sv
// ----------------------------------------------------------------------------
// EEG P2 packet parser checker
// Port-level checks on the parser's output words, bound to the core.
// ----------------------------------------------------------------------------
module eegp2_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_valid,
   input  logic                          csr_ready,
   input  logic [eegp2_pkg::COUNT_W-1:0] csr_count,
   input  logic                          rsp_valid,
   input  logic                          rsp_ready,
   input  logic [eegp2_pkg::BYTE_W-1:0]  rsp_number,
   input  eegp2_pkg::chan_type           rsp_chan0,
   input  eegp2_pkg::chan_type           rsp_chan5
);

   // Shadow of the last channel count written.
   logic [eegp2_pkg::COUNT_W-1:0] count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= eegp2_pkg::COUNT_RESET;
      end else if (csr_valid && csr_ready) begin
         count_ff <= csr_count;
      end
   end

   // No packet word is shown right after reset.
   assert property (@(posedge clock) $past(reset) |-> !rsp_valid)
      else $error("packet word valid right after reset");

   // A stalled packet word holds its packet number and channel 0.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_number) && $stable(rsp_chan0))
      else $error("stalled packet word changed");

   // The offset keeps every channel at or above -512; channel 0 is checked.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_chan0 >= -17'sd512)
      else $error("channel 0 below offset floor");

   // The last channel reads zero when fewer than six channels are enabled.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (count_ff < eegp2_pkg::COUNT_RESET) |-> rsp_chan5 == '0)
      else $error("unused channel 5 not zero");

endmodule

bind eeg_p2_packet_parser_core eegp2_checker u_eegp2_checker (
   .clock      (clock),
   .reset      (reset),
   .csr_valid  (csr_ch.valid),
   .csr_ready  (csr_ch.ready),
   .csr_count  (csr_ch.channel_count),
   .rsp_valid  (rsp_ch.valid),
   .rsp_ready  (rsp_ch.ready),
   .rsp_number (rsp_ch.packet_number),
   .rsp_chan0  (rsp_ch.chan0),
   .rsp_chan5  (rsp_ch.chan5)
);

FILE: test/tb_eeg_p2_packet_parser_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// P2 packet parser core testbench
// Feeds the parser a serial byte stream that is mostly well-formed packets
// with random content, mixed with noise and broken sync pairs. A scoreboard
// runs its own packet parser on every accepted byte and checks each parsed
// packet word field by field. The channel count changes between phases, also
// in the middle of a packet. Both sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb_eeg_p2_packet_parser_core;

   localparam int QUIET_LIMIT   = 2000;
   localparam int SETTLE_CYCLES = 8;
   localparam int RANDOM_BYTES  = 700;
   localparam int LONG_HOLD     = 300;
   localparam int PACKET_BYTES  = 17;
   localparam int PRINT_LIMIT   = 200;

   // One parsed packet word as seen on the result channel.
   typedef struct {
      logic [eegp2_pkg::BYTE_W-1:0] packet_number;
      logic [eegp2_pkg::BYTE_W-1:0] switches;
      eegp2_pkg::chan_type          chan [eegp2_pkg::CHANNELS];
   } packet_type;

   // Tracks the parser state and holds the packet words still to come.
   class packet_scoreboard;
      eegp2_pkg::phase_type          parse_phase;
      logic [eegp2_pkg::POS_W-1:0]   byte_pos;
      logic [eegp2_pkg::BYTE_W-1:0]  held_number;
      logic [eegp2_pkg::WORD_W-1:0]  chan_words [eegp2_pkg::CHANNELS];
      logic [eegp2_pkg::COUNT_W-1:0] chan_count;
      packet_type                    pending_packets [$];
      int                            failures;
      int                            packets_checked;

      function new();
         parse_phase = eegp2_pkg::PH_HUNT;
         byte_pos = '0;
         held_number = '0;
         foreach (chan_words[i]) chan_words[i] = '0;
         chan_count = eegp2_pkg::COUNT_RESET;
         failures = 0;
         packets_checked = 0;
      endfunction

      task report(input string msg);
         if (failures < PRINT_LIMIT) $display("ERROR at %0t: %s", $realtime, msg);
         failures++;
      endtask

      function void set_channel_count(logic [eegp2_pkg::COUNT_W-1:0] v);
         chan_count = v;
      endfunction

      function int pending();
         return pending_packets.size();
      endfunction

      // Advances the parser by one accepted byte word.
      function void note_rx_byte(logic [eegp2_pkg::BYTE_W-1:0] b);
         int                           active;
         int                           ch;
         packet_type                   pkt;
         logic [eegp2_pkg::CHAN_W-1:0] diff;
         active = (chan_count > eegp2_pkg::CHANNELS) ? eegp2_pkg::CHANNELS : chan_count;
         case (parse_phase)
            eegp2_pkg::PH_HUNT: begin
               if (b == eegp2_pkg::SYNC_FIRST) parse_phase = eegp2_pkg::PH_SYNC2;
            end
            eegp2_pkg::PH_SYNC2: begin
               parse_phase = (b == eegp2_pkg::SYNC_SECOND) ?
                             eegp2_pkg::PH_VERSION : eegp2_pkg::PH_HUNT;
            end
            eegp2_pkg::PH_VERSION: begin
               parse_phase = eegp2_pkg::PH_NUMBER;
            end
            eegp2_pkg::PH_NUMBER: begin
               held_number = b;
               byte_pos = '0;
               parse_phase = eegp2_pkg::PH_DATA;
            end
            eegp2_pkg::PH_DATA: begin
               if (byte_pos < eegp2_pkg::DATA_BYTES) begin
                  ch = int'(byte_pos >> 1);
                  // Words of unused channels are left untouched.
                  if (ch < active) begin
                     if (!byte_pos[0]) chan_words[ch] = {b, 8'h00};
                     else chan_words[ch] = chan_words[ch] + eegp2_pkg::WORD_W'(b);
                  end
                  byte_pos = byte_pos + 1'b1;
               end else begin
                  // Switches byte: the packet is complete.
                  parse_phase = eegp2_pkg::PH_HUNT;
                  pkt.packet_number = held_number;
                  pkt.switches = b;
                  for (int j = 0; j < eegp2_pkg::CHANNELS; j++) begin
                     diff = {1'b0, chan_words[j]} - eegp2_pkg::CHAN_OFFSET;
                     pkt.chan[j] = (j < active) ? eegp2_pkg::chan_type'(diff) :
                                                  eegp2_pkg::chan_type'(0);
                  end
                  pending_packets.insert(pending_packets.size(), pkt);
               end
            end
            default: begin
               parse_phase = eegp2_pkg::PH_HUNT;
            end
         endcase
      endfunction

      // Compares a result word with the oldest expected packet.
      task check_packet(input packet_type got);
         packet_type exp;
         if (pending_packets.size() == 0) begin
            report($sformatf("packet number %0d arrived with none expected",
                             got.packet_number));
            return;
         end
         exp = pending_packets.pop_front();
         if (got.packet_number !== exp.packet_number)
            report($sformatf("packet %0d: packet_number expected %0d, got %0d",
                             packets_checked, exp.packet_number, got.packet_number));
         if (got.switches !== exp.switches)
            report($sformatf("packet %0d: switches expected %0d, got %0d",
                             packets_checked, exp.switches, got.switches));
         for (int j = 0; j < eegp2_pkg::CHANNELS; j++) begin
            if (got.chan[j] !== exp.chan[j])
               report($sformatf("packet %0d: chan%0d expected %0d, got %0d",
                                packets_checked, j, exp.chan[j], got.chan[j]));
         end
         packets_checked++;
      endtask
   endclass

   logic clock;
   logic reset;

   eegp2_req_if req_ch ();
   eegp2_rsp_if rsp_ch ();
   eegp2_csr_if csr_ch ();

   eeg_p2_packet_parser_core dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   packet_scoreboard              sb;
   bit                            tx_idle;
   bit                            rx_idle;
   int                            hold_cycles;
   int                            quiet_cycles;
   int                            sent_bytes;
   logic [eegp2_pkg::BYTE_W-1:0]  byte_q [$];
   logic [eegp2_pkg::BYTE_W-1:0]  carry_q [$];
   logic [eegp2_pkg::COUNT_W-1:0] first_counts [4] = '{3'd0, 3'd7, 3'd1, 3'd6};

   initial clock = 1'b0;
   always #2 clock = ~clock;

   // Byte value for packet fields, biased toward the extremes and the sync byte.
   function automatic logic [eegp2_pkg::BYTE_W-1:0] rand_data();
      case ($urandom_range(0, 7))
         0: return 8'h00;
         1: return 8'hFF;
         2: return eegp2_pkg::SYNC_FIRST;
         default: return eegp2_pkg::BYTE_W'($urandom_range(0, 255));
      endcase
   endfunction

   // Queues one well-formed packet; bytes past keep go to the next phase.
   function automatic void push_packet(int keep);
      logic [eegp2_pkg::BYTE_W-1:0] pkt [$];
      pkt.insert(pkt.size(), eegp2_pkg::SYNC_FIRST);
      pkt.insert(pkt.size(), eegp2_pkg::SYNC_SECOND);
      for (int i = 0; i < PACKET_BYTES - 2; i++) pkt.insert(pkt.size(), rand_data());
      foreach (pkt[i]) begin
         if (i < keep) byte_q.insert(byte_q.size(), pkt[i]);
         else carry_q.insert(carry_q.size(), pkt[i]);
      end
   endfunction

   // Offers one byte word after a random gap and waits for its acceptance.
   task automatic send_byte(input logic [eegp2_pkg::BYTE_W-1:0] b);
      int gap;
      gap = tx_idle ? $urandom_range(0, 19) : 0;
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.rx_byte <= b;
      @(posedge clock);
      while (req_ch.ready !== 1'b1) @(posedge clock);
   endtask

   task automatic send_queued();
      while (byte_q.size() > 0) send_byte(byte_q.pop_front());
   endtask

   task automatic write_count(input logic [eegp2_pkg::COUNT_W-1:0] v);
      csr_ch.valid <= 1'b1;
      csr_ch.channel_count <= v;
      @(posedge clock);
      while (csr_ch.ready !== 1'b1) @(posedge clock);
      csr_ch.valid <= 1'b0;
   endtask

   // Stops sending and waits until every expected packet has come out.
   task automatic drain();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Result side: random stalls, plus one long hold-off on request.
   initial begin
      int stall;
      rsp_ch.ready <= 1'b0;
      @(posedge clock);
      forever begin
         if (hold_cycles > 0) begin
            stall = hold_cycles;
            hold_cycles = 0;
         end else begin
            stall = rx_idle ? $urandom_range(0, 19) : 0;
         end
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         @(posedge clock);
         while (rsp_ch.valid !== 1'b1) @(posedge clock);
      end
   end

   // Monitor: feeds accepted words to the scoreboard.
   always @(posedge clock) begin
      packet_type got;
      if (!reset) begin
         if (req_ch.valid === 1'b1 && req_ch.ready === 1'b1)
            sb.note_rx_byte(req_ch.rx_byte);
         if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
            got.packet_number = rsp_ch.packet_number;
            got.switches = rsp_ch.switches;
            got.chan[0] = rsp_ch.chan0;
            got.chan[1] = rsp_ch.chan1;
            got.chan[2] = rsp_ch.chan2;
            got.chan[3] = rsp_ch.chan3;
            got.chan[4] = rsp_ch.chan4;
            got.chan[5] = rsp_ch.chan5;
            sb.check_packet(got);
         end
         if (csr_ch.valid === 1'b1 && csr_ch.ready === 1'b1)
            sb.set_channel_count(csr_ch.channel_count);
      end
   end

   // Watchdog: ends the run when no word moves for too long.
   always @(posedge clock) begin
      if (reset || (req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
          (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) ||
          (csr_ch.valid === 1'b1 && csr_ch.ready === 1'b1)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      int                            phase_idx;
      int                            sel;
      logic [eegp2_pkg::BYTE_W-1:0]  b;
      logic [eegp2_pkg::COUNT_W-1:0] cnt;
      logic [eegp2_pkg::BYTE_W-1:0]  directed [22] = '{
         eegp2_pkg::SYNC_FIRST, eegp2_pkg::SYNC_SECOND, 8'hFF, 8'h00,
         8'h00, 8'h00, 8'hFF, 8'hFF, 8'h02, 8'h00,
         8'h01, 8'hFF, 8'h80, 8'h00, 8'h7F, 8'hFF,
         8'hFF,
         eegp2_pkg::SYNC_FIRST, eegp2_pkg::SYNC_FIRST, eegp2_pkg::SYNC_SECOND, 8'h00, 8'hFF
      };

      sb = new();
      tx_idle = 1'b0;
      rx_idle = 1'b0;
      hold_cycles = 0;
      quiet_cycles = 0;
      sent_bytes = 0;
      reset <= 1'b1;
      req_ch.valid <= 1'b0;
      req_ch.rx_byte <= '0;
      csr_ch.valid <= 1'b0;
      csr_ch.channel_count <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed: channel word extremes and a sync pair broken by a repeat
      // of the first sync byte, followed by bytes the hunter ignores.
      write_count(eegp2_pkg::COUNT_RESET);
      foreach (directed[i]) byte_q.insert(byte_q.size(), directed[i]);
      send_queued();
      drain();

      // Random phases, each under its own channel count. A packet cut at the
      // end of a phase is finished in the next one under the new count.
      phase_idx = 0;
      while (sent_bytes < RANDOM_BYTES) begin
         cnt = (phase_idx < 4) ? first_counts[phase_idx] :
                                 eegp2_pkg::COUNT_W'($urandom_range(0, 7));
         write_count(cnt);
         tx_idle = ($urandom_range(0, 2) != 0);
         rx_idle = ($urandom_range(0, 2) != 0);
         while (carry_q.size() > 0) byte_q.insert(byte_q.size(), carry_q.pop_front());
         if (phase_idx == 1) begin
            // Back-to-back packets against a long receiver hold-off.
            tx_idle = 1'b0;
            hold_cycles = LONG_HOLD;
            repeat (6) push_packet(PACKET_BYTES);
         end else begin
            repeat ($urandom_range(2, 6)) begin
               sel = $urandom_range(0, 9);
               case (sel)
                  7: begin
                     repeat ($urandom_range(1, 6)) byte_q.insert(byte_q.size(), rand_data());
                  end
                  8: begin
                     // First sync byte followed by anything but the second.
                     b = eegp2_pkg::BYTE_W'($urandom_range(0, 255));
                     if (b == eegp2_pkg::SYNC_SECOND) b = eegp2_pkg::SYNC_FIRST;
                     byte_q.insert(byte_q.size(), eegp2_pkg::SYNC_FIRST);
                     byte_q.insert(byte_q.size(), b);
                  end
                  9: begin
                     // Truncated packet: the next bytes are parsed as its body.
                     push_packet($urandom_range(1, PACKET_BYTES - 1));
                     carry_q.delete();
                  end
                  default: push_packet(PACKET_BYTES);
               endcase
            end
            if ($urandom_range(0, 2) == 0) push_packet($urandom_range(1, PACKET_BYTES - 1));
         end
         sent_bytes += byte_q.size();
         send_queued();
         drain();
         phase_idx++;
      end

      repeat (20) @(posedge clock);
      if (sb.pending() != 0)
         sb.report($sformatf("%0d expected packets never arrived", sb.pending()));
      if (sb.failures == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
